// ===== src/gbfp_pkg.sv =====
`default_nettype none

package gbfp_pkg;

   // Largest payload length that a frame may carry.
   localparam int MAX_PAYLOAD = 128;

   // Frame position counter: headers 0..5, payload, then two check bytes.
   localparam int POS_WIDTH = $clog2(MAX_PAYLOAD + 8);
   localparam int LEN_WIDTH = $clog2(MAX_PAYLOAD + 1);

   localparam logic [POS_WIDTH-1:0] POS_SYNC_FIRST  = POS_WIDTH'(0);
   localparam logic [POS_WIDTH-1:0] POS_SYNC_SECOND = POS_WIDTH'(1);
   localparam logic [POS_WIDTH-1:0] POS_CLASS       = POS_WIDTH'(2);
   localparam logic [POS_WIDTH-1:0] POS_ID          = POS_WIDTH'(3);
   localparam logic [POS_WIDTH-1:0] POS_LEN_LOW     = POS_WIDTH'(4);
   localparam logic [POS_WIDTH-1:0] POS_LEN_HIGH    = POS_WIDTH'(5);
   localparam logic [POS_WIDTH-1:0] POS_PAYLOAD     = POS_WIDTH'(6);

   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   localparam int INDEX_WIDTH = 7;

   // Configuration register indexes.
   localparam logic [2:0] CSR_NAV_CLASS          = 3'd0;
   localparam logic [2:0] CSR_ID_POSITION        = 3'd1;
   localparam logic [2:0] CSR_ID_HIGH_PRECISION  = 3'd2;
   localparam logic [2:0] CSR_ID_END_OF_EPOCH    = 3'd3;
   localparam logic [2:0] CSR_LEN_POSITION       = 3'd4;
   localparam logic [2:0] CSR_LEN_HIGH_PRECISION = 3'd5;
   localparam logic [2:0] CSR_LEN_END_OF_EPOCH   = 3'd6;
   localparam logic [2:0] CSR_HIGH_PRECISION_MODE = 3'd7;

   typedef enum logic [1:0] {
      KIND_POSITION       = 2'd0,
      KIND_HIGH_PRECISION = 2'd1,
      KIND_END_OF_EPOCH   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] nav_class;
      logic [7:0] id_position;
      logic [7:0] id_high_precision;
      logic [7:0] id_end_of_epoch;
      logic [7:0] len_position;
      logic [7:0] len_high_precision;
      logic [7:0] len_end_of_epoch;
      logic       high_precision_mode;
   } cfg_type;

   typedef struct packed {
      logic                   payload_valid;
      logic [INDEX_WIDTH-1:0] payload_index;
      logic [7:0]             payload_byte;
      logic [1:0]             message_kind;
      logic                   frame_done;
      logic                   frame_good;
      logic                   epoch_done;
      logic                   epoch_good;
   } result_type;

endpackage

`default_nettype wire

// ===== src/gbfp_csr_regs.sv =====
`default_nettype none

module gbfp_csr_regs (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [2:0]       wr_index,
   input  wire logic [7:0]       wr_data,
   output gbfp_pkg::cfg_type     cfg
);
   import gbfp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_NAV_CLASS:           cfg_in.nav_class           = wr_data;
            CSR_ID_POSITION:         cfg_in.id_position         = wr_data;
            CSR_ID_HIGH_PRECISION:   cfg_in.id_high_precision   = wr_data;
            CSR_ID_END_OF_EPOCH:     cfg_in.id_end_of_epoch     = wr_data;
            CSR_LEN_POSITION:        cfg_in.len_position        = wr_data;
            CSR_LEN_HIGH_PRECISION:  cfg_in.len_high_precision  = wr_data;
            CSR_LEN_END_OF_EPOCH:    cfg_in.len_end_of_epoch    = wr_data;
            CSR_HIGH_PRECISION_MODE: cfg_in.high_precision_mode = wr_data[0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nav_class           <= 8'd1;
         cfg_ff.id_position         <= 8'd7;
         cfg_ff.id_high_precision   <= 8'd20;
         cfg_ff.id_end_of_epoch     <= 8'd97;
         cfg_ff.len_position        <= 8'd92;
         cfg_ff.len_high_precision  <= 8'd36;
         cfg_ff.len_end_of_epoch    <= 8'd4;
         cfg_ff.high_precision_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/gbfp_frame_core.sv =====
`default_nettype none

module gbfp_frame_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic [7:0]        rx_byte,
   input  wire gbfp_pkg::cfg_type cfg,
   output gbfp_pkg::result_type   result
);
   import gbfp_pkg::*;

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   kind_type             kind_ff, kind_in;
   logic [7:0]           len_low_ff, len_low_in;
   logic [LEN_WIDTH-1:0] len_held_ff, len_held_in;
   logic [7:0]           sum_a_ff, sum_a_in;
   logic [7:0]           sum_b_ff, sum_b_in;
   logic [7:0]           check_a_ff, check_a_in;
   logic                 pos_seen_ff, pos_seen_in;
   logic                 hp_seen_ff, hp_seen_in;

   logic [POS_WIDTH-1:0]   end_pos;
   logic [INDEX_WIDTH-1:0] offset;
   logic [7:0]             add_a;
   logic [7:0]             add_b;
   logic [7:0]             need;
   logic [15:0]            frame_len;
   logic                   good;

   assign end_pos   = POS_PAYLOAD + POS_WIDTH'(len_held_ff);
   assign offset    = INDEX_WIDTH'(pos_ff - POS_PAYLOAD);
   assign add_a     = sum_a_ff + rx_byte;
   assign add_b     = sum_b_ff + add_a;
   assign frame_len = {rx_byte, len_low_ff};
   assign good      = (check_a_ff == sum_a_ff) && (rx_byte == sum_b_ff);

   always_comb begin
      case (kind_ff)
         KIND_POSITION:       need = cfg.len_position;
         KIND_HIGH_PRECISION: need = cfg.len_high_precision;
         default:             need = cfg.len_end_of_epoch;
      endcase
   end

   always_comb begin
      pos_in      = pos_ff;
      kind_in     = kind_ff;
      len_low_in  = len_low_ff;
      len_held_in = len_held_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      check_a_in  = check_a_ff;
      pos_seen_in = pos_seen_ff;
      hp_seen_in  = hp_seen_ff;
      result      = '0;

      if (pos_ff == POS_SYNC_FIRST) begin
         pos_in = (rx_byte == SYNC_FIRST) ? POS_SYNC_SECOND : POS_SYNC_FIRST;
      end else if (pos_ff == POS_SYNC_SECOND) begin
         pos_in = (rx_byte == SYNC_SECOND) ? POS_CLASS : POS_SYNC_FIRST;
      end else if (pos_ff == POS_CLASS) begin
         if (rx_byte == cfg.nav_class) begin
            // Restart the sums with the class byte.
            sum_a_in = rx_byte;
            sum_b_in = rx_byte;
            pos_in   = POS_ID;
         end else begin
            pos_in = POS_SYNC_FIRST;
         end
      end else if (pos_ff == POS_ID) begin
         pos_in   = POS_LEN_LOW;
         sum_a_in = add_a;
         sum_b_in = add_b;
         if (rx_byte == cfg.id_position) begin
            kind_in = KIND_POSITION;
         end else if (rx_byte == cfg.id_high_precision) begin
            kind_in = KIND_HIGH_PRECISION;
         end else if (rx_byte == cfg.id_end_of_epoch) begin
            kind_in = KIND_END_OF_EPOCH;
         end else begin
            pos_in   = POS_SYNC_FIRST;
            sum_a_in = sum_a_ff;
            sum_b_in = sum_b_ff;
         end
      end else if (pos_ff == POS_LEN_LOW) begin
         len_low_in = rx_byte;
         sum_a_in   = add_a;
         sum_b_in   = add_b;
         pos_in     = POS_LEN_HIGH;
      end else if (pos_ff == POS_LEN_HIGH) begin
         sum_a_in = add_a;
         sum_b_in = add_b;
         if (frame_len == {8'd0, need} && frame_len <= 16'(MAX_PAYLOAD)) begin
            len_held_in = LEN_WIDTH'(frame_len);
            pos_in      = POS_PAYLOAD;
         end else begin
            pos_in = POS_SYNC_FIRST;
         end
      end else if (pos_ff < end_pos) begin
         result.payload_valid = 1'b1;
         result.payload_index = offset;
         result.payload_byte  = rx_byte;
         result.message_kind  = kind_ff;
         sum_a_in = add_a;
         sum_b_in = add_b;
         pos_in   = pos_ff + POS_WIDTH'(1);
      end else if (pos_ff == end_pos) begin
         check_a_in = rx_byte;
         pos_in     = pos_ff + POS_WIDTH'(1);
      end else begin
         result.message_kind = kind_ff;
         result.frame_done   = 1'b1;
         result.frame_good   = good;
         if (good) begin
            case (kind_ff)
               KIND_POSITION:       pos_seen_in = 1'b1;
               KIND_HIGH_PRECISION: hp_seen_in  = 1'b1;
               default: begin
                  result.epoch_done = 1'b1;
                  result.epoch_good = pos_seen_ff &&
                                      (!cfg.high_precision_mode || hp_seen_ff);
                  pos_seen_in = 1'b0;
                  hp_seen_in  = 1'b0;
               end
            endcase
         end
         pos_in = POS_SYNC_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_SYNC_FIRST;
         kind_ff     <= KIND_POSITION;
         len_low_ff  <= '0;
         len_held_ff <= '0;
         sum_a_ff    <= '0;
         sum_b_ff    <= '0;
         check_a_ff  <= '0;
         pos_seen_ff <= 1'b0;
         hp_seen_ff  <= 1'b0;
      end else if (advance) begin
         pos_ff      <= pos_in;
         kind_ff     <= kind_in;
         len_low_ff  <= len_low_in;
         len_held_ff <= len_held_in;
         sum_a_ff    <= sum_a_in;
         sum_b_ff    <= sum_b_in;
         check_a_ff  <= check_a_in;
         pos_seen_ff <= pos_seen_in;
         hp_seen_ff  <= hp_seen_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/gnss_binary_frame_parser_unit.sv =====
`default_nettype none

// Channel   Direction  Transfer when              Contents
// req_      in         req_tvalid & req_tready    one received byte
// rsp_      out        rsp_tvalid & rsp_tready    one result per byte
// csr_      in         csr_valid & csr_ready      register index and write data
//
// One byte is taken every cycle while the result side is not stalled; each byte
// gives exactly one result, through the input register, then the result register.
// The rate is set by the combinational update of the frame position counter
// and Fletcher sums between the two registers.
// Reset is synchronous and active high; it restores the register defaults
// and returns the parser to sync hunting.
// A stalled result holds its register; the input register still takes a
// byte while it is empty, then req_tready follows rsp_tready.

module gnss_binary_frame_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // slave side: tdata = rx_byte[7:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   // master side
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: payload_index[6:0], payload_byte[14:7], frame_good[15],
   //        epoch_done[16], epoch_good[17], zero fill [23:18]
   output logic [23:0]      rsp_tdata,
   // tuser: payload_valid[0], message_kind[2:1]
   output logic [2:0]       rsp_tuser,
   output logic             rsp_tlast,      // frame_done
   // configuration writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_data
);
   import gbfp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       advance;
   cfg_type    cfg;
   result_type result;

   // Move the held byte into the result register when that register is free.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   gbfp_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   gbfp_frame_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff <= in_byte_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.epoch_good, rsp_ff.epoch_done, rsp_ff.frame_good,
                        rsp_ff.payload_byte, rsp_ff.payload_index};
   assign rsp_tuser  = {rsp_ff.message_kind, rsp_ff.payload_valid};
   assign rsp_tlast  = rsp_ff.frame_done;

   // A result register never takes a new item while a stalled one is waiting.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !advance)
      else $error("result overwritten while stalled");

   // A frame end never carries a payload byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_done |-> !rsp_ff.payload_valid)
      else $error("payload flagged on frame end");

   // An epoch is reported only on a good end of epoch frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.epoch_done |->
         rsp_ff.frame_done && rsp_ff.frame_good &&
         rsp_ff.message_kind == KIND_END_OF_EPOCH)
      else $error("epoch reported outside a good end of epoch frame");

   // A held byte that cannot advance keeps the input side closed.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input taken while held byte is blocked");

endmodule

`default_nettype wire
